@@ src/mcl_pkg.sv @@
// ----------------------------------------------------------------------------
// mcl_pkg
// Types, constants and fixed-point helpers for the cable hydrodynamic load
// pipeline (Q16.16 arithmetic, saturation, pipelined square root steps).
// ----------------------------------------------------------------------------
package mcl_pkg;

    typedef logic signed [31:0] q_t;   // Q16.16
    typedef logic signed [63:0] p_t;   // Q32.32 product / wide sum
    typedef logic [30:0]        cfg_t; // unsigned register value

    localparam int  NUM_STAGES     = 20;
    localparam int  SQRT_FIRST     = 7;
    localparam int  SQRT_STAGES    = 8;
    localparam int  SQRT_PER_STAGE = 4;
    localparam int  CFG_IDX_W      = 3;
    localparam p_t  Q_ONE          = 64'sd65536;
    localparam p_t  Q_HALF         = 64'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WATER_DENSITY    = 3'd0,
        REG_AIR_DENSITY      = 3'd1,
        REG_SECTION_AREA     = 3'd2,
        REG_HYDRO_DIAMETER   = 3'd3,
        REG_GRAVITY_ACCEL    = 3'd4,
        REG_DRAG_COEFF       = 3'd5,
        REG_ADDED_MASS_COEFF = 3'd6
    } cfg_idx_t;

    localparam cfg_t RST_WATER_DENSITY    = 31'd67174400;
    localparam cfg_t RST_AIR_DENSITY      = 31'd80282;
    localparam cfg_t RST_SECTION_AREA     = 31'd0;
    localparam cfg_t RST_HYDRO_DIAMETER   = 31'd0;
    localparam cfg_t RST_GRAVITY_ACCEL    = 31'd642908;
    localparam cfg_t RST_DRAG_COEFF       = 31'd65536;
    localparam cfg_t RST_ADDED_MASS_COEFF = 31'd65536;

    typedef struct packed {
        logic in_water;
        q_t   tangent_x;
        q_t   tangent_y;
        q_t   tangent_z;
        q_t   rel_vel_x;
        q_t   rel_vel_y;
        q_t   rel_vel_z;
        q_t   fluid_acc_x;
        q_t   fluid_acc_y;
        q_t   fluid_acc_z;
    } in_item_t;

    typedef struct packed {
        q_t   force_x;
        q_t   force_y;
        q_t   force_z;
        logic saturated;
    } out_item_t;

    typedef struct packed {
        logic [63:0] n;  // remainder
        logic [63:0] r;  // root
    } sq_t;

    function automatic p_t wide(q_t x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic p_t uwide(cfg_t x);
        return {33'd0, x};
    endfunction

    // round to nearest, ties up: floor((p + 2^15) / 2^16)
    function automatic p_t rnd16(p_t p);
        return (p + Q_HALF) >>> 16;
    endfunction

    function automatic logic ovf32(p_t x);
        return (x[63:31] != '0) && (x[63:31] != '1);
    endfunction

    function automatic q_t sat32(p_t x);
        if (ovf32(x)) begin
            return x[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return x[31:0];
    endfunction

    // four iterations of the bit-pair square root, block blk of eight
    function automatic sq_t sqrt_steps(sq_t s, int blk);
        logic [63:0] bitv;
        logic [63:0] trial;
        sq_t         o;
        o = s;
        for (int j = 0; j < SQRT_PER_STAGE; j++) begin
            bitv  = 64'd1 << (62 - 2 * (SQRT_PER_STAGE * blk + j));
            trial = o.r + bitv;
            if (o.n >= trial) begin
                o.n = o.n - trial;
                o.r = (o.r >> 1) + bitv;
            end else begin
                o.r = o.r >> 1;
            end
        end
        return o;
    endfunction

endpackage

@@ src/morison_cable_load.sv @@
// ----------------------------------------------------------------------------
// morison_cable_load
// Morison load per unit length on a cable point: buoyancy, normal drag and
// added-mass inertia, Q16.16 with saturation at every step.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir
//  input   | s_valid, s_ready, s_data (in_item_t)    | in
//  result  | m_valid, m_ready, m_data (out_item_t)   | out
//  config  | cfg_wr_en, cfg_addr, cfg_wr_data        | in
//
// One item per cycle while the output is not stalled; the datapath has 20 stages
// (eight of them the pipelined square root of |v_n|^2, four steps each).
// Synchronous active-low reset empties the pipeline and loads register
// defaults. A stall on m_ready freezes every stage at once; s_ready drops
// only while the output holds an item that is not taken.
module morison_cable_load
    import mcl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  cfg_t                 cfg_wr_data
);

    typedef struct {
        logic        clip;
        q_t          t[3];
        q_t          v[3];
        q_t          a[3];
        cfg_t        rho;
        p_t          p1[3];
        p_t          p2[3];
        p_t          pk;
        p_t          pr;
        p_t          pg;
        q_t          dv;
        q_t          da;
        q_t          rd;
        q_t          ra;
        q_t          dvt[3];
        q_t          at[3];
        q_t          vn[3];
        q_t          kd;
        q_t          buoy;
        q_t          m[3];
        logic [63:0] sq[3];
        logic [63:0] sn;
        logic [63:0] sr;
        q_t          inr[3];
        q_t          s;
        q_t          frc[3];
    } pipe_t;

    cfg_t water_density_reg, air_density_reg, section_area_reg, hydro_diameter_reg;
    cfg_t gravity_accel_reg, drag_coeff_reg, added_mass_coeff_reg;

    pipe_t st_reg  [NUM_STAGES];
    pipe_t st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic en;

    assign en      = !vld_reg[NUM_STAGES-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            water_density_reg    <= RST_WATER_DENSITY;
            air_density_reg      <= RST_AIR_DENSITY;
            section_area_reg     <= RST_SECTION_AREA;
            hydro_diameter_reg   <= RST_HYDRO_DIAMETER;
            gravity_accel_reg    <= RST_GRAVITY_ACCEL;
            drag_coeff_reg       <= RST_DRAG_COEFF;
            added_mass_coeff_reg <= RST_ADDED_MASS_COEFF;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WATER_DENSITY:    water_density_reg    <= cfg_wr_data;
                REG_AIR_DENSITY:      air_density_reg      <= cfg_wr_data;
                REG_SECTION_AREA:     section_area_reg     <= cfg_wr_data;
                REG_HYDRO_DIAMETER:   hydro_diameter_reg   <= cfg_wr_data;
                REG_GRAVITY_ACCEL:    gravity_accel_reg    <= cfg_wr_data;
                REG_DRAG_COEFF:       drag_coeff_reg       <= cfg_wr_data;
                REG_ADDED_MASS_COEFF: added_mass_coeff_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        p_t   sum;
        p_t   onepca;
        q_t   x1;
        q_t   x2;
        q_t   ca;
        q_t   drag;
        sq_t  sqv;
        logic c;

        ca = {1'b0, added_mass_coeff_reg};
        st_next[0] = st_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            st_next[k] = st_reg[k-1];
        end

        // stage 0: capture, first products
        st_next[0].clip  = 1'b0;
        st_next[0].t[0]  = s_data.tangent_x;
        st_next[0].t[1]  = s_data.tangent_y;
        st_next[0].t[2]  = s_data.tangent_z;
        st_next[0].v[0]  = s_data.rel_vel_x;
        st_next[0].v[1]  = s_data.rel_vel_y;
        st_next[0].v[2]  = s_data.rel_vel_z;
        st_next[0].a[0]  = s_data.in_water ? s_data.fluid_acc_x : '0;
        st_next[0].a[1]  = s_data.in_water ? s_data.fluid_acc_y : '0;
        st_next[0].a[2]  = s_data.in_water ? s_data.fluid_acc_z : '0;
        st_next[0].rho   = s_data.in_water ? water_density_reg : air_density_reg;
        for (int i = 0; i < 3; i++) begin
            st_next[0].p1[i] = wide(st_next[0].v[i]) * wide(st_next[0].t[i]);
            st_next[0].p2[i] = wide(st_next[0].a[i]) * wide(st_next[0].t[i]);
        end
        st_next[0].pk = uwide(st_next[0].rho) * uwide(hydro_diameter_reg);
        st_next[0].pr = uwide(st_next[0].rho) * uwide(section_area_reg);

        // stage 1: dot products, rho*d, rho*A
        c   = st_reg[0].clip;
        sum = rnd16(st_reg[0].p1[0]) + rnd16(st_reg[0].p1[1]) + rnd16(st_reg[0].p1[2]);
        st_next[1].dv = sat32(sum);
        c = c | ovf32(sum);
        sum = rnd16(st_reg[0].p2[0]) + rnd16(st_reg[0].p2[1]) + rnd16(st_reg[0].p2[2]);
        st_next[1].da = sat32(sum);
        c = c | ovf32(sum);
        st_next[1].rd = sat32(rnd16(st_reg[0].pk));
        st_next[1].ra = sat32(rnd16(st_reg[0].pr));
        c = c | ovf32(rnd16(st_reg[0].pk)) | ovf32(rnd16(st_reg[0].pr));
        st_next[1].clip = c;

        // stage 2: projections on the tangent, *Cd, *g
        for (int i = 0; i < 3; i++) begin
            st_next[2].p1[i] = wide(st_reg[1].dv) * wide(st_reg[1].t[i]);
            st_next[2].p2[i] = wide(st_reg[1].da) * wide(st_reg[1].t[i]);
        end
        st_next[2].pk = wide(st_reg[1].rd) * uwide(drag_coeff_reg);
        st_next[2].pg = wide(st_reg[1].ra) * uwide(gravity_accel_reg);

        // stage 3: round projections, rho*d*Cd, buoyancy
        c = st_reg[2].clip;
        for (int i = 0; i < 3; i++) begin
            st_next[3].dvt[i] = sat32(rnd16(st_reg[2].p1[i]));
            st_next[3].at[i]  = sat32(rnd16(st_reg[2].p2[i]));
            c = c | ovf32(rnd16(st_reg[2].p1[i])) | ovf32(rnd16(st_reg[2].p2[i]));
        end
        st_next[3].rd   = sat32(rnd16(st_reg[2].pk));
        st_next[3].buoy = sat32(rnd16(st_reg[2].pg));
        c = c | ovf32(rnd16(st_reg[2].pk)) | ovf32(rnd16(st_reg[2].pg));
        st_next[3].clip = c;

        // stage 4: normal velocity, inertia products
        c      = st_reg[3].clip;
        onepca = Q_ONE + wide(ca);
        c      = c | ovf32(onepca);
        for (int i = 0; i < 3; i++) begin
            sum = wide(st_reg[3].v[i]) - wide(st_reg[3].dvt[i]);
            st_next[4].vn[i] = sat32(sum);
            c = c | ovf32(sum);
            st_next[4].p1[i] = wide(sat32(onepca)) * wide(st_reg[3].a[i]);
            st_next[4].p2[i] = wide(ca) * wide(st_reg[3].at[i]);
        end
        st_next[4].pk   = wide(st_reg[3].rd) * Q_HALF;
        st_next[4].clip = c;

        // stage 5: drag gain, inertia term, squares
        c = st_reg[4].clip;
        st_next[5].kd = sat32(rnd16(st_reg[4].pk));
        c = c | ovf32(rnd16(st_reg[4].pk));
        for (int i = 0; i < 3; i++) begin
            x1  = sat32(rnd16(st_reg[4].p1[i]));
            x2  = sat32(rnd16(st_reg[4].p2[i]));
            sum = wide(x1) - wide(x2);
            st_next[5].m[i] = sat32(sum);
            c = c | ovf32(rnd16(st_reg[4].p1[i])) | ovf32(rnd16(st_reg[4].p2[i]))
                  | ovf32(sum);
            st_next[5].sq[i] = wide(st_reg[4].vn[i]) * wide(st_reg[4].vn[i]);
        end
        st_next[5].clip = c;

        // stage 6: sum of squares, rho*A*m
        st_next[6].sn = st_reg[5].sq[0] + st_reg[5].sq[1] + st_reg[5].sq[2];
        st_next[6].sr = '0;
        for (int i = 0; i < 3; i++) begin
            st_next[6].p1[i] = wide(st_reg[5].ra) * wide(st_reg[5].m[i]);
        end

        // stages 7..14: square root, four bit pairs each
        for (int b = 0; b < SQRT_STAGES; b++) begin
            sqv.n = st_reg[SQRT_FIRST+b-1].sn;
            sqv.r = st_reg[SQRT_FIRST+b-1].sr;
            sqv   = sqrt_steps(sqv, b);
            st_next[SQRT_FIRST+b].sn = sqv.n;
            st_next[SQRT_FIRST+b].sr = sqv.r;
        end
        c = st_reg[SQRT_FIRST-1].clip;
        for (int i = 0; i < 3; i++) begin
            st_next[SQRT_FIRST].inr[i] = sat32(rnd16(st_reg[SQRT_FIRST-1].p1[i]));
            c = c | ovf32(rnd16(st_reg[SQRT_FIRST-1].p1[i]));
        end
        st_next[SQRT_FIRST].clip = c;

        // stage 15: clip |v_n|
        if (st_reg[14].sr > 64'h7FFF_FFFF) begin
            st_next[15].s    = 32'sh7FFF_FFFF;
            st_next[15].clip = 1'b1;
        end else begin
            st_next[15].s = st_reg[14].sr[31:0];
        end

        // stage 16: kd*|v_n|
        st_next[16].pk = wide(st_reg[15].kd) * wide(st_reg[15].s);

        // stage 17
        st_next[17].s    = sat32(rnd16(st_reg[16].pk));
        st_next[17].clip = st_reg[16].clip | ovf32(rnd16(st_reg[16].pk));

        // stage 18: drag products
        for (int i = 0; i < 3; i++) begin
            st_next[18].p1[i] = wide(st_reg[17].s) * wide(st_reg[17].vn[i]);
        end

        // stage 19: sum up, output register
        c = st_reg[18].clip;
        for (int i = 0; i < 3; i++) begin
            drag = sat32(rnd16(st_reg[18].p1[i]));
            c    = c | ovf32(rnd16(st_reg[18].p1[i]));
            sum  = wide(drag) + wide(st_reg[18].inr[i]);
            if (i == 2) begin
                sum = sum + wide(st_reg[18].buoy);
            end
            st_next[19].frc[i] = sat32(sum);
            c = c | ovf32(sum);
        end
        st_next[19].clip = c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign m_data.force_x   = st_reg[NUM_STAGES-1].frc[0];
    assign m_data.force_y   = st_reg[NUM_STAGES-1].frc[1];
    assign m_data.force_z   = st_reg[NUM_STAGES-1].frc[2];
    assign m_data.saturated = st_reg[NUM_STAGES-1].clip;

`ifndef SYNTHESIS
    // after reset the result side is empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // finished root fits 33 bits
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[14] |-> (st_reg[14].sr <= 64'h1_0000_0000))
        else $error("square root out of range");

    // remainder of a floor root never exceeds twice the root
    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[14] |-> (st_reg[14].sn <= (st_reg[14].sr << 1)))
        else $error("square root remainder too large");
`endif

endmodule

@@ sim/morison_cable_load_tb.sv @@
// ----------------------------------------------------------------------------
// morison_cable_load_tb
// Self-checking bench for the cable Morison load pipeline: a directed table
// of items, then random items in water and air, with random gaps on both
// sides, a long output stall and a full drain. Every result is checked
// field by field, in order, against a Q16.16 predictor or a fixed row.
// ----------------------------------------------------------------------------
module morison_cable_load_tb;
    import mcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 20;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 540;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    cfg_t                 cfg_wr_data = '0;

    always #6 aclk = ~aclk;

    morison_cable_load u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor copy of the registers
    longint    rho_water, rho_air, area, diam, grav, cd, cam;
    out_item_t force_q[$];
    int        n_errors = 0;
    int        n_mismatch = 0;
    bit        hold_out = 1'b0;
    int        idle_cycles = 0;
    bit        clip;

    function automatic longint fsat(longint x);
        if (x > 64'sd2147483647) begin
            clip = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            clip = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint fround(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return fsat(fround(a * b));
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic out_item_t predict_force(in_item_t it);
        longint t[3], v[3], a[3], vn[3], f[3];
        longint rho, dv, da, kd, s, ra, opc, drag, at, m;
        longint unsigned ss;
        out_item_t o;
        clip = 1'b0;
        ss = 0;
        rho = it.in_water ? rho_water : rho_air;
        t[0] = longint'(it.tangent_x);  t[1] = longint'(it.tangent_y);
        t[2] = longint'(it.tangent_z);
        v[0] = longint'(it.rel_vel_x);  v[1] = longint'(it.rel_vel_y);
        v[2] = longint'(it.rel_vel_z);
        a[0] = it.in_water ? longint'(it.fluid_acc_x) : 0;
        a[1] = it.in_water ? longint'(it.fluid_acc_y) : 0;
        a[2] = it.in_water ? longint'(it.fluid_acc_z) : 0;
        dv = fsat(fround(v[0]*t[0]) + fround(v[1]*t[1]) + fround(v[2]*t[2]));
        for (int i = 0; i < 3; i++) begin
            vn[i] = fsat(v[i] - fmul(dv, t[i]));
            ss += longint'(vn[i] * vn[i]);
        end
        s = fsat(isqrt(ss));
        kd = fmul(fmul(fmul(rho, diam), cd), 64'sd32768);
        s = fmul(kd, s);
        ra = fmul(rho, area);
        opc = fsat(64'sd65536 + cam);
        da = fsat(fround(a[0]*t[0]) + fround(a[1]*t[1]) + fround(a[2]*t[2]));
        for (int i = 0; i < 3; i++) begin
            drag = fmul(s, vn[i]);
            at = fmul(da, t[i]);
            m = fsat(fmul(opc, a[i]) - fmul(cam, at));
            f[i] = drag + fmul(ra, m);
        end
        f[2] += fmul(ra, grav);
        o.force_x = q_t'(fsat(f[0]));
        o.force_y = q_t'(fsat(f[1]));
        o.force_z = q_t'(fsat(f[2]));
        o.saturated = clip;
        return o;
    endfunction

    task automatic write_reg(cfg_idx_t idx, cfg_t val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WATER_DENSITY:    rho_water = longint'(val);
            REG_AIR_DENSITY:      rho_air = longint'(val);
            REG_SECTION_AREA:     area = longint'(val);
            REG_HYDRO_DIAMETER:   diam = longint'(val);
            REG_GRAVITY_ACCEL:    grav = longint'(val);
            REG_DRAG_COEFF:       cd = longint'(val);
            REG_ADDED_MASS_COEFF: cam = longint'(val);
            default: ;
        endcase
    endtask

    // caller is on the falling edge after the last accepted item
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (force_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // presents one item after an idle gap of length gap; caller is on a falling edge.
    // Valid is left high on return, the next item or wait_drain takes it down.
    task automatic send_item(in_item_t it, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        force_q.push_back(predict_force(it));
        @(negedge aclk);
    endtask

    // back-to-back burst: valid stays high between items
    task automatic send_burst(int n);
        in_item_t it;
        for (int k = 0; k < n; k++) begin
            it = rand_item();
            s_valid <= 1'b1;
            s_data  <= it;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            force_q.push_back(predict_force(it));
            @(negedge aclk);
        end
    endtask

    function automatic q_t rand_q(int mode);
        case (mode)
            0: return q_t'($urandom);
            1: return q_t'($urandom_range(131072)) - 32'sd65536;
            default: return q_t'($urandom_range(2097152)) - 32'sd1048576;
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int m;
        m = $urandom_range(9);
        m = (m == 0) ? 0 : (m < 5 ? 1 : 2);
        it.in_water    = $urandom_range(3) != 0;
        it.tangent_x   = rand_q(m == 0 ? 0 : 1);
        it.tangent_y   = rand_q(m == 0 ? 0 : 1);
        it.tangent_z   = rand_q(m == 0 ? 0 : 1);
        it.rel_vel_x   = rand_q(m);
        it.rel_vel_y   = rand_q(m);
        it.rel_vel_z   = rand_q(m);
        it.fluid_acc_x = rand_q(m);
        it.fluid_acc_y = rand_q(m);
        it.fluid_acc_z = rand_q(m);
        return it;
    endfunction

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t result;
    } stim_row_t;

    localparam q_t QMAX = 32'sh7FFF_FFFF;
    localparam q_t QMIN = 32'sh8000_0000;
    localparam q_t QONE = 32'sd65536;

    stim_row_t directed[$];

    task automatic add_row(logic w, q_t tx, q_t ty, q_t tz, q_t vx, q_t vy, q_t vz,
                           q_t ax, q_t ay, q_t az, bit fx, out_item_t r);
        stim_row_t row;
        row.item = '{w, tx, ty, tz, vx, vy, vz, ax, ay, az};
        row.fixed = fx;
        row.result = r;
        directed.push_back(row);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (force_q.size() == 0) begin
                n_errors++;
                if (n_mismatch++ < 10) $display("unexpected item %h", m_data);
            end else begin
                out_item_t e;
                e = force_q.pop_front();
                if (e !== m_data) begin
                    n_errors++;
                    if (n_mismatch++ < 10)
                        $display("mismatch: expected %h %h %h %b got %h %h %h %b",
                                 e.force_x, e.force_y, e.force_z, e.saturated,
                                 m_data.force_x, m_data.force_y, m_data.force_z,
                                 m_data.saturated);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        int w;
        forever begin
            @(negedge aclk);
            if (hold_out) begin
                m_ready <= 1'b0;
                repeat (120) @(negedge aclk);
                hold_out = 1'b0;
            end
            w = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
            if (w == 0 || $urandom_range(1)) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (w - 1) @(negedge aclk);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("morison_cable_load_tb: FAIL");
            $finish;
        end
    end

    initial begin
        out_item_t r;
        int gap;
        rho_water = longint'(RST_WATER_DENSITY);  rho_air = longint'(RST_AIR_DENSITY);
        area = longint'(RST_SECTION_AREA);        diam = longint'(RST_HYDRO_DIAMETER);
        grav = longint'(RST_GRAVITY_ACCEL);       cd = longint'(RST_DRAG_COEFF);
        cam = longint'(RST_ADDED_MASS_COEFF);

        // after reset A and d are zero, so every force is zero; the oversized
        // normal velocity still clips its length and raises the flag
        r = '0;
        r.saturated = 1'b1;
        add_row(1, QONE, 0, 0, QMAX, QMIN, QMAX, QMAX, QMAX, QMIN, 1, r);
        add_row(0, 0, 0, 0, QMIN, QMAX, 0, QMIN, QMIN, QMAX, 1, r);
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) begin
            send_item(directed[i].item, 0);
            if (directed[i].fixed) force_q[$] = directed[i].result;
        end
        wait_drain();

        // realistic cable, then table of extremes against the predictor
        write_reg(REG_SECTION_AREA, 31'd655);
        write_reg(REG_HYDRO_DIAMETER, 31'd1892);
        write_reg(REG_DRAG_COEFF, 31'd78643);
        write_reg(REG_ADDED_MASS_COEFF, 31'd65536);
        directed.delete();
        add_row(1, QONE, 0, 0, QONE, QONE, 0, QONE, 0, QONE, 0, r);
        add_row(0, 0, 0, QONE, QONE, -QONE, QONE, QONE, QONE, QONE, 0, r);
        add_row(1, 32'sd3*QONE, QONE, -QONE, QONE, 0, 0, 0, QONE, 0, 0, r);
        add_row(1, 0, 0, 0, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0, r);
        add_row(1, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0, r);
        add_row(0, QMAX, QMIN, QMAX, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 0, r);
        add_row(1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, r);
        add_row(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, r);
        foreach (directed[i]) send_item(directed[i].item, 0);
        wait_drain();

        // extreme register settings
        write_reg(REG_WATER_DENSITY, 31'h7FFF_FFFF);
        write_reg(REG_AIR_DENSITY, 31'h7FFF_FFFF);
        write_reg(REG_SECTION_AREA, 31'h7FFF_FFFF);
        write_reg(REG_HYDRO_DIAMETER, 31'h7FFF_FFFF);
        write_reg(REG_GRAVITY_ACCEL, 31'h7FFF_FFFF);
        write_reg(REG_DRAG_COEFF, 31'h7FFF_FFFF);
        write_reg(REG_ADDED_MASS_COEFF, 31'h7FFF_FFFF);
        foreach (directed[i]) send_item(directed[i].item, 0);
        for (int k = 0; k < 40; k++) send_item(rand_item(), $urandom_range(3));
        wait_drain();
        write_reg(REG_WATER_DENSITY, 31'd0);
        write_reg(REG_AIR_DENSITY, 31'd0);
        write_reg(REG_GRAVITY_ACCEL, 31'd0);
        write_reg(REG_DRAG_COEFF, 31'd0);
        write_reg(REG_ADDED_MASS_COEFF, 31'd0);
        for (int k = 0; k < 30; k++) send_item(rand_item(), $urandom_range(3));
        wait_drain();

        // random register sets, random items with random gaps
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_WATER_DENSITY, cfg_t'($urandom_range(70000000)));
            write_reg(REG_AIR_DENSITY, cfg_t'($urandom_range(200000)));
            write_reg(REG_SECTION_AREA, ph == 5 ? cfg_t'($urandom)
                                                : cfg_t'($urandom_range(70000)));
            write_reg(REG_HYDRO_DIAMETER, ph == 5 ? cfg_t'($urandom)
                                                  : cfg_t'($urandom_range(70000)));
            write_reg(REG_GRAVITY_ACCEL, cfg_t'($urandom_range(700000)));
            write_reg(REG_DRAG_COEFF, cfg_t'($urandom_range(200000)));
            write_reg(REG_ADDED_MASS_COEFF, cfg_t'($urandom_range(200000)));
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
                send_item(rand_item(), gap);
                if (ph == 0 && k == 40) begin
                    hold_out = 1'b1;
                    send_burst(60);
                end
            end
            wait_drain();
        end

        wait_drain();
        if (n_errors == 0 && force_q.size() == 0) begin
            $display("morison_cable_load_tb: PASS");
        end else begin
            $display("morison_cable_load_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ morison_cable_load.f @@
src/mcl_pkg.sv
src/morison_cable_load.sv
sim/morison_cable_load_tb.sv
